FILE: design/straddling_checkerboard_cipher_core_assert.svh
// ----------------------------------------------------------------------------
// Straddling checkerboard cipher core: assertion macros
// Shorthand for the concurrent checks at the end of the top level. Both
// macros sample on i_clk and are disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef STRADDLING_CHECKERBOARD_CIPHER_CORE_ASSERT_SVH
`define STRADDLING_CHECKERBOARD_CIPHER_CORE_ASSERT_SVH

// A condition that must hold at every clock edge.
`define SCC_ASSERT_ALWAYS(lbl, cond) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error("invariant check failed");

// A consequence that must hold in the cycle after its trigger.
`define SCC_ASSERT_NEXT(lbl, trig, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (trig) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

FILE: design/scc_pkg.sv
// ----------------------------------------------------------------------------
// Straddling checkerboard cipher package
// Types, character codes, the checkerboard table and the digit helpers.
// ----------------------------------------------------------------------------
package scc_pkg;

    // Basic sizes.
    localparam int NUM_LETTERS = 26;
    localparam int KEY_LEN     = 5;
    localparam int MAX_RESULTS = 3;
    localparam int CHAR_W      = 8;
    localparam int DIGIT_W     = 4;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 4;
    localparam int LETTER_W    = $clog2(NUM_LETTERS);

    localparam logic [2:0] GROUP_LEN = 3'd5;

    typedef logic [CHAR_W-1:0]   t_char;
    typedef logic [DIGIT_W-1:0]  t_digit;
    typedef logic [LETTER_W-1:0] t_letter;
    typedef logic [KEY_LEN-1:0]  t_key_sel;

    // One result item waiting in the output buffer.
    typedef struct packed {
        t_char ch;
        logic  invalid;
    } t_result;

    // Outcome of a code lookup.
    typedef struct packed {
        logic    valid;
        t_letter idx;
    } t_decode;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_MODE     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KEY_BASE = 3'd1;

    // Mode codes.
    localparam logic MODE_ENCRYPT = 1'b0;
    localparam logic MODE_DECRYPT = 1'b1;

    // ASCII codes.
    localparam t_char CHAR_SPACE   = 8'h20;
    localparam t_char CHAR_ZERO    = 8'h30;
    localparam t_char CHAR_NINE    = 8'h39;
    localparam t_char CHAR_UPPER_A = 8'h41;
    localparam t_char CHAR_UPPER_Z = 8'h5A;
    localparam t_char CHAR_LOWER_A = 8'h61;
    localparam t_char CHAR_LOWER_Z = 8'h7A;
    localparam t_char CHAR_NONE    = 8'h00;

    // Prefix digits that open a two-digit code.
    localparam t_digit PREFIX_LO  = 4'd3;
    localparam t_digit PREFIX_MID = 4'd5;
    localparam t_digit PREFIX_HI  = 4'd7;

    localparam t_digit DIGIT_TEN = 4'd10;
    localparam t_key_sel KEY_SEL_FIRST = t_key_sel'(1);

    // Checkerboard codes split into tens and ones; a zero tens digit marks a
    // one-digit code.
    localparam t_digit BOARD_TENS [NUM_LETTERS] = '{
        4'd0, 4'd3, 4'd3, 4'd0, 4'd0, 4'd3, 4'd3, 4'd3, 4'd3, 4'd3, 4'd7, 4'd7, 4'd7,
        4'd7, 4'd0, 4'd7, 4'd7, 4'd5, 4'd0, 4'd0, 4'd5, 4'd5, 4'd5, 4'd5, 4'd0, 4'd5
    };
    localparam t_digit BOARD_ONES [NUM_LETTERS] = '{
        4'd6, 4'd8, 4'd2, 4'd4, 4'd8, 4'd0, 4'd6, 4'd4, 4'd9, 4'd1, 4'd8, 4'd2, 4'd0,
        4'd6, 4'd9, 4'd9, 4'd1, 4'd8, 4'd2, 4'd0, 4'd2, 4'd0, 4'd6, 4'd4, 4'd1, 4'd9
    };

    // A key register value folded into 0..9.
    function automatic t_digit key_mod10(t_digit k);
        return (k >= DIGIT_TEN) ? t_digit'(k - DIGIT_TEN) : k;
    endfunction

    // Sum of two decimal digits mod 10.
    function automatic t_digit add_mod10(t_digit a, t_digit b);
        logic [DIGIT_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return (s >= {1'b0, DIGIT_TEN}) ? t_digit'(s - {1'b0, DIGIT_TEN}) : t_digit'(s);
    endfunction

    // Difference of two decimal digits mod 10.
    function automatic t_digit sub_mod10(t_digit a, t_digit b);
        return (a >= b) ? t_digit'(a - b) : t_digit'(a + DIGIT_TEN - b);
    endfunction

    function automatic logic is_prefix(t_digit d);
        return (d == PREFIX_LO) || (d == PREFIX_MID) || (d == PREFIX_HI);
    endfunction

    // Finds the letter whose code has the given tens and ones digits.
    function automatic t_decode decode_code(t_digit tens, t_digit ones);
        t_decode r;
        r = '0;
        for (int i = 0; i < NUM_LETTERS; i++) begin
            if (BOARD_TENS[i] == tens && BOARD_ONES[i] == ones) begin
                r.valid = 1'b1;
                r.idx   = t_letter'(i);
            end
        end
        return r;
    endfunction

endpackage

FILE: design/scc_stream_if.sv
// ----------------------------------------------------------------------------
// Straddling checkerboard cipher stream interfaces
// Valid/ready channels for message characters in and cipher results out.
// ----------------------------------------------------------------------------
interface scc_in_if;
    import scc_pkg::*;

    logic  valid;
    logic  ready;
    t_char in_char;
    logic  end_of_message;

    modport source (output valid, output in_char, output end_of_message, input ready);
    modport sink   (input valid, input in_char, input end_of_message, output ready);
endinterface

interface scc_out_if;
    import scc_pkg::*;

    logic  valid;
    logic  ready;
    t_char out_char;
    logic  invalid;
    logic  last_of_run;

    modport source (output valid, output out_char, output invalid, output last_of_run,
                    input ready);
    modport sink   (input valid, input out_char, input invalid, input last_of_run,
                    output ready);
endinterface

FILE: design/straddling_checkerboard_cipher_core.sv
// ----------------------------------------------------------------------------
// Straddling checkerboard cipher core
// Encrypts letters to keyed digit groups or decrypts digits back to letters.
// ----------------------------------------------------------------------------
// Each input character is worked out in the cycle it is accepted, and its zero
// to three results are loaded into a small output buffer that hands out one
// result per cycle while o_out.ready is high. The next character is accepted
// in the same cycle as the last result of the previous one is taken, or at
// once when the buffer is empty, so a character with several results holds
// the input until all but its last result have gone. In encryption the number
// of results depends on the code length and on whether a group space falls
// due; in decryption a flagged character that ends a message while a prefix
// is held gives two results.
// Configuration writes must be made while no results are pending.
// ----------------------------------------------------------------------------
`include "straddling_checkerboard_cipher_core_assert.svh"

module straddling_checkerboard_cipher_core (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [scc_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [scc_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    scc_in_if.sink                             i_in,
    scc_out_if.source                          o_out
);
    import scc_pkg::*;

    // Configuration and cipher state.
    logic      r_mode;
    t_digit    r_key [KEY_LEN];
    t_key_sel  r_key_sel;
    logic [2:0] r_grp;
    t_digit    r_pfx;
    logic      r_pfx_vld;

    // Output buffer.
    t_result   r_buf [MAX_RESULTS];
    logic [1:0] r_left;

    // Next state and per-character results.
    t_key_sel  n_key_sel;
    logic [2:0] n_grp;
    t_digit    n_pfx;
    logic      n_pfx_vld;
    t_result   w_res [MAX_RESULTS];
    logic [1:0] w_n;

    logic      in_xfer;
    logic      out_xfer;
    t_key_sel  w_sel1;
    t_key_sel  w_sel2;
    t_digit    w_k0;
    t_digit    w_k1;
    logic      w_is_upper;
    logic      w_is_lower;
    logic      w_is_letter;
    logic      w_is_digit;
    t_char     w_off;
    t_letter   w_idx;
    logic      w_two;
    t_digit    w_e1;
    t_digit    w_e2;
    logic      w_sp1;
    logic      w_sp2;
    logic [2:0] w_g1;
    logic [2:0] w_g2;
    t_digit    w_dec_digit;
    t_decode   w_dec;
    logic      w_at_start;

    assign in_xfer  = i_in.valid && i_in.ready;
    assign out_xfer = o_out.valid && o_out.ready;

    // Key position as a rotating one-hot select; pick the current and next digit.
    assign w_sel1 = {r_key_sel[KEY_LEN-2:0], r_key_sel[KEY_LEN-1]};
    assign w_sel2 = {w_sel1[KEY_LEN-2:0], w_sel1[KEY_LEN-1]};

    always_comb begin
        w_k0 = '0;
        w_k1 = '0;
        for (int i = 0; i < KEY_LEN; i++) begin
            w_k0 = w_k0 | (r_key[i] & {DIGIT_W{r_key_sel[i]}});
            w_k1 = w_k1 | (r_key[i] & {DIGIT_W{w_sel1[i]}});
        end
        w_k0 = key_mod10(w_k0);
        w_k1 = key_mod10(w_k1);
    end

    // Character classes.
    assign w_is_upper  = (i_in.in_char >= CHAR_UPPER_A) && (i_in.in_char <= CHAR_UPPER_Z);
    assign w_is_lower  = (i_in.in_char >= CHAR_LOWER_A) && (i_in.in_char <= CHAR_LOWER_Z);
    assign w_is_letter = w_is_upper || w_is_lower;
    assign w_is_digit  = (i_in.in_char >= CHAR_ZERO) && (i_in.in_char <= CHAR_NINE);

    // Encrypt path: table lookup, keyed digits and group spacing.
    assign w_off = i_in.in_char - (w_is_upper ? CHAR_UPPER_A : CHAR_LOWER_A);
    assign w_idx = w_off[LETTER_W-1:0];
    assign w_two = (BOARD_TENS[w_idx] != '0);
    assign w_e1  = add_mod10(w_two ? BOARD_TENS[w_idx] : BOARD_ONES[w_idx], w_k0);
    assign w_e2  = add_mod10(BOARD_ONES[w_idx], w_k1);
    assign w_sp1 = (r_grp >= GROUP_LEN);
    assign w_g1  = w_sp1 ? 3'd1 : r_grp + 3'd1;
    assign w_sp2 = w_two && (w_g1 >= GROUP_LEN);
    assign w_g2  = w_sp2 ? 3'd1 : w_g1 + 3'd1;

    // Decrypt path: remove the key digit and look up the code.
    assign w_dec_digit = sub_mod10(i_in.in_char[DIGIT_W-1:0], w_k0);
    assign w_dec       = decode_code(r_pfx_vld ? r_pfx : t_digit'(0), w_dec_digit);

    // Results of one character and the state it leaves behind.
    always_comb begin
        w_n       = '0;
        n_key_sel = r_key_sel;
        n_grp     = r_grp;
        n_pfx     = r_pfx;
        n_pfx_vld = r_pfx_vld;
        for (int i = 0; i < MAX_RESULTS; i++) begin
            w_res[i] = '0;
        end

        if (r_mode == MODE_ENCRYPT) begin
            if (w_is_letter) begin
                if (w_sp1) begin
                    w_res[w_n] = '{ch: CHAR_SPACE, invalid: 1'b0};
                    w_n        = w_n + 2'd1;
                end
                w_res[w_n] = '{ch: CHAR_ZERO | t_char'(w_e1), invalid: 1'b0};
                w_n        = w_n + 2'd1;
                if (w_two) begin
                    if (w_sp2) begin
                        w_res[w_n] = '{ch: CHAR_SPACE, invalid: 1'b0};
                        w_n        = w_n + 2'd1;
                    end
                    w_res[w_n] = '{ch: CHAR_ZERO | t_char'(w_e2), invalid: 1'b0};
                    w_n        = w_n + 2'd1;
                    n_key_sel  = w_sel2;
                    n_grp      = w_g2;
                end else begin
                    n_key_sel = w_sel1;
                    n_grp     = w_g1;
                end
            end else begin
                w_res[w_n] = '{ch: CHAR_NONE, invalid: 1'b1};
                w_n        = w_n + 2'd1;
            end
        end else begin
            if (w_is_digit) begin
                n_key_sel = w_sel1;
                if (!r_pfx_vld && is_prefix(w_dec_digit)) begin
                    n_pfx     = w_dec_digit;
                    n_pfx_vld = 1'b1;
                end else begin
                    w_res[w_n] = w_dec.valid
                        ? t_result'{ch: CHAR_UPPER_A + t_char'(w_dec.idx), invalid: 1'b0}
                        : t_result'{ch: CHAR_NONE, invalid: 1'b1};
                    w_n        = w_n + 2'd1;
                    n_pfx      = '0;
                    n_pfx_vld  = 1'b0;
                end
            end else if (i_in.in_char != CHAR_SPACE) begin
                w_res[w_n] = '{ch: CHAR_NONE, invalid: 1'b1};
                w_n        = w_n + 2'd1;
            end
            // A prefix still held at the end of the message is flagged.
            if (i_in.end_of_message && n_pfx_vld) begin
                w_res[w_n] = '{ch: CHAR_NONE, invalid: 1'b1};
                w_n        = w_n + 2'd1;
            end
        end

        if (i_in.end_of_message) begin
            n_key_sel = KEY_SEL_FIRST;
            n_grp     = '0;
            n_pfx     = '0;
            n_pfx_vld = 1'b0;
        end
    end

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_ENCRYPT;
            for (int i = 0; i < KEY_LEN; i++) begin
                r_key[i] <= '0;
            end
        end else if (i_cfg_we) begin
            if (i_cfg_index == CFG_MODE) begin
                r_mode <= i_cfg_data[0];
            end
            for (int i = 0; i < KEY_LEN; i++) begin
                if (i_cfg_index == CFG_KEY_BASE + CFG_IDX_W'(i)) begin
                    r_key[i] <= i_cfg_data;
                end
            end
        end
    end

    // Cipher state advances on each input transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_sel <= KEY_SEL_FIRST;
            r_grp     <= '0;
            r_pfx     <= '0;
            r_pfx_vld <= 1'b0;
        end else if (in_xfer) begin
            r_key_sel <= n_key_sel;
            r_grp     <= n_grp;
            r_pfx     <= n_pfx;
            r_pfx_vld <= n_pfx_vld;
        end
    end

    // Output buffer count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= '0;
        end else if (in_xfer) begin
            r_left <= w_n;
        end else if (out_xfer) begin
            r_left <= r_left - 2'd1;
        end
    end

    // Output buffer payload: load on input, shift toward the head on output.
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_buf <= w_res;
        end else if (out_xfer) begin
            for (int i = 0; i < MAX_RESULTS - 1; i++) begin
                r_buf[i] <= r_buf[i+1];
            end
        end
    end

    // Handshake and result fields.
    assign i_in.ready        = (r_left == 2'd0) || ((r_left == 2'd1) && o_out.ready);
    assign o_out.valid       = (r_left != 2'd0);
    assign o_out.out_char    = r_buf[0].ch;
    assign o_out.invalid     = r_buf[0].invalid;
    assign o_out.last_of_run = (r_left == 2'd1);

    // Cipher state as it stands at the start of a message.
    assign w_at_start = (r_grp == 3'd0) && !r_pfx_vld && (r_key_sel == KEY_SEL_FIRST);

    // Checks.
    `SCC_ASSERT_ALWAYS(a_key_sel_onehot, $onehot(r_key_sel))
    `SCC_ASSERT_ALWAYS(a_prefix_digit, !r_pfx_vld || is_prefix(r_pfx))
    `SCC_ASSERT_NEXT(a_eom_clears, in_xfer && i_in.end_of_message, w_at_start)
    `SCC_ASSERT_NEXT(a_load_count, in_xfer, r_left == $past(w_n))

endmodule
